@@ rtl/mfnp_pkg.sv @@
package mfnp_pkg;

  typedef enum logic [3:0] {
    PH_HDR_ID    = 4'd0,
    PH_HDR_LEN   = 4'd1,
    PH_HDR_FMT   = 4'd2,
    PH_HDR_NTRK  = 4'd3,
    PH_HDR_DIV   = 4'd4,
    PH_TRK_ID    = 4'd5,
    PH_TRK_LEN   = 4'd6,
    PH_DELTA     = 4'd7,
    PH_STATUS    = 4'd8,
    PH_META_TYPE = 4'd9,
    PH_LEN_VLQ   = 4'd10,
    PH_SKIP      = 4'd11,
    PH_DATA1     = 4'd12,
    PH_DATA2     = 4'd13,
    PH_DONE      = 4'd14,
    PH_ERROR     = 4'd15
  } phase_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_NOTE   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] ERR_HDR_ID  = 3'd1;
  localparam logic [2:0] ERR_TRK_ID  = 3'd2;
  localparam logic [2:0] ERR_LONG    = 3'd3;
  localparam logic [2:0] ERR_TRUNC   = 3'd4;
  localparam logic [2:0] ERR_NO_STAT = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] track_index;
    logic [31:0] note_ticks;
    logic [3:0]  channel;
    logic [7:0]  note;
    logic [7:0]  velocity;
    logic [15:0] file_format;
    logic [15:0] track_total;
    logic [15:0] tick_division;
    logic [2:0]  error_code;
    logic        last_of_run;
  } out_item_t;

  function automatic logic [7:0] hdr_tag(input logic [1:0] i);
    case (i)
      2'd0: hdr_tag = 8'h4d;
      2'd1: hdr_tag = 8'h54;
      2'd2: hdr_tag = 8'h68;
      default: hdr_tag = 8'h64;
    endcase
  endfunction

  function automatic logic [7:0] trk_tag(input logic [1:0] i);
    case (i)
      2'd0: trk_tag = 8'h4d;
      2'd1: trk_tag = 8'h54;
      2'd2: trk_tag = 8'h72;
      default: trk_tag = 8'h6b;
    endcase
  endfunction

endpackage

@@ rtl/mfnp_out_queue.sv @@
module mfnp_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [1:0]          push_count,
  input  mfnp_pkg::out_item_t push_a,
  input  mfnp_pkg::out_item_t push_b,
  output logic                has_room,
  output logic                out_valid,
  output mfnp_pkg::out_item_t out_item,
  input  logic                out_ready
);
  import mfnp_pkg::*;

  // four-entry queue; accept a byte only when two results fit
  out_item_t  slots [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] fill;
  logic       pop;
  logic [2:0] pushed;

  assign pop       = out_valid && out_ready;
  assign pushed    = push ? {1'b0, push_count} : 3'd0;
  assign out_valid = fill != 3'd0;
  assign out_item  = slots[rd_ptr];
  assign has_room  = fill <= 3'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 2'd0;
      wr_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      if (pushed != 3'd0) slots[wr_ptr] <= push_a;
      if (pushed == 3'd2) slots[wr_ptr + 2'd1] <= push_b;
      wr_ptr <= wr_ptr + pushed[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + pushed - {2'd0, pop};
    end
  end
endmodule

@@ rtl/midi_file_note_on_parser.sv @@
// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_ready  mfnp_pkg::in_item_t (file byte, end flag)
// out      out  out_valid/out_ready mfnp_pkg::out_item_t (one result)
//
// One byte per cycle, back to back while in_ready is high: the byte is parsed the cycle it is taken
// and its zero to two results enter a four-deep output queue.
// in_ready drops only while the queue holds three or more results.
// rst is synchronous, active high; it clears parse state and the queue.
// After done or an error, bytes are still taken but produce nothing.
module midi_file_note_on_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfnp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mfnp_pkg::out_item_t out_data
);
  import mfnp_pkg::*;

  phase_t      phase, phase_next;
  logic [2:0]  field_byte_count, field_byte_count_next;
  logic [31:0] gather_word, gather_word_next;
  logic [15:0] tracks_expected, tracks_expected_next;
  logic [15:0] current_track, current_track_next;
  logic [31:0] track_length, track_length_next;
  logic [31:0] track_bytes_used, track_bytes_used_next;
  logic [31:0] tick_total, tick_total_next;
  logic [7:0]  running_status, running_status_next;
  logic [2:0]  quantity_bytes, quantity_bytes_next;
  logic [31:0] skip_left, skip_left_next;
  logic [7:0]  first_data, first_data_next;
  logic [15:0] header_format, header_format_next;

  logic        accept;
  logic [7:0]  b;
  logic [1:0]  n;
  out_item_t   ra, rb;
  logic [31:0] used;
  logic [31:0] vlq_word;
  logic [2:0]  vlq_count;
  logic [31:0] skip_dec;
  logic [15:0] trk_inc;

  assign accept = in_valid && in_ready;
  assign b      = in_data.in_byte;
  assign vlq_word  = {gather_word[24:0], b[6:0]};
  assign vlq_count = quantity_bytes + 3'd1;
  assign skip_dec  = (skip_left != 32'd0) ? skip_left - 32'd1 : skip_left;
  assign trk_inc   = current_track + 16'd1;

  function automatic logic one_data(input logic [7:0] s);
    one_data = (s[7:4] == 4'hc) || (s[7:4] == 4'hd);
  endfunction

  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    gather_word_next      = gather_word;
    tracks_expected_next  = tracks_expected;
    current_track_next    = current_track;
    track_length_next     = track_length;
    tick_total_next       = tick_total;
    running_status_next   = running_status;
    quantity_bytes_next   = quantity_bytes;
    skip_left_next        = skip_left;
    first_data_next       = first_data;
    header_format_next    = header_format;
    n  = 2'd0;
    ra = '0;
    rb = '0;
    used = (phase >= PH_DELTA && phase <= PH_DATA2) ?
           track_bytes_used + 32'd1 : track_bytes_used;
    track_bytes_used_next = used;

    // event boundary handling is inlined below via a small helper flag
    begin : parse
      logic boundary;
      logic [2:0] err;
      boundary = 1'b0;
      err = 3'd0;
      unique case (phase)
        PH_HDR_ID: begin
          if (b != hdr_tag(field_byte_count[1:0])) err = ERR_HDR_ID;
          else if (field_byte_count == 3'd3) begin
            field_byte_count_next = 3'd0;
            phase_next = PH_HDR_LEN;
          end else field_byte_count_next = field_byte_count + 3'd1;
        end
        PH_HDR_LEN: begin
          if (field_byte_count == 3'd3) begin
            field_byte_count_next = 3'd0;
            gather_word_next = 32'd0;
            phase_next = PH_HDR_FMT;
          end else field_byte_count_next = field_byte_count + 3'd1;
        end
        PH_HDR_FMT, PH_HDR_NTRK, PH_HDR_DIV: begin
          gather_word_next = {gather_word[23:0], b};
          if (field_byte_count == 3'd0) field_byte_count_next = 3'd1;
          else begin
            field_byte_count_next = 3'd0;
            gather_word_next = 32'd0;
            if (phase == PH_HDR_FMT) begin
              header_format_next = {gather_word[7:0], b};
              phase_next = PH_HDR_NTRK;
            end else if (phase == PH_HDR_NTRK) begin
              tracks_expected_next = {gather_word[7:0], b};
              phase_next = PH_HDR_DIV;
            end else begin
              ra.kind = KIND_HEADER;
              ra.file_format = header_format;
              ra.track_total = tracks_expected;
              ra.tick_division = {gather_word[7:0], b};
              n = 2'd1;
              current_track_next = 16'd0;
              if (tracks_expected == 16'd0) begin
                rb.kind = KIND_DONE;
                n = 2'd2;
                phase_next = PH_DONE;
              end else phase_next = PH_TRK_ID;
            end
          end
        end
        PH_TRK_ID: begin
          if (b != trk_tag(field_byte_count[1:0])) err = ERR_TRK_ID;
          else if (field_byte_count == 3'd3) begin
            field_byte_count_next = 3'd0;
            gather_word_next = 32'd0;
            phase_next = PH_TRK_LEN;
          end else field_byte_count_next = field_byte_count + 3'd1;
        end
        PH_TRK_LEN: begin
          gather_word_next = {gather_word[23:0], b};
          if (field_byte_count == 3'd3) begin
            field_byte_count_next = 3'd0;
            track_length_next = {gather_word[23:0], b};
            used = 32'd0;
            track_bytes_used_next = 32'd0;
            tick_total_next = 32'd0;
            running_status_next = 8'd0;
            boundary = 1'b1;
          end else field_byte_count_next = field_byte_count + 3'd1;
        end
        PH_DELTA: begin
          gather_word_next = vlq_word;
          quantity_bytes_next = vlq_count;
          if (b[7]) begin
            if (vlq_count >= 3'd4) err = ERR_LONG;
          end else begin
            tick_total_next = tick_total + vlq_word;
            phase_next = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b[7]) begin
            if (b == 8'hff) begin
              running_status_next = 8'd0;
              phase_next = PH_META_TYPE;
            end else if (b == 8'hf0 || b == 8'hf7) begin
              running_status_next = 8'd0;
              gather_word_next = 32'd0;
              quantity_bytes_next = 3'd0;
              phase_next = PH_LEN_VLQ;
            end else begin
              running_status_next = (b < 8'hf0) ? b : 8'd0;
              if (b[7:4] == 4'h9) phase_next = PH_DATA1;
              else begin
                skip_left_next = one_data(b) ? 32'd1 : 32'd2;
                phase_next = PH_SKIP;
              end
            end
          end else if (running_status == 8'd0) err = ERR_NO_STAT;
          else if (running_status[7:4] == 4'h9) begin
            first_data_next = b;
            phase_next = PH_DATA2;
          end else if (one_data(running_status)) boundary = 1'b1;
          else begin
            skip_left_next = 32'd1;
            phase_next = PH_SKIP;
          end
        end
        PH_META_TYPE: begin
          gather_word_next = 32'd0;
          quantity_bytes_next = 3'd0;
          phase_next = PH_LEN_VLQ;
        end
        PH_LEN_VLQ: begin
          gather_word_next = vlq_word;
          quantity_bytes_next = vlq_count;
          if (b[7]) begin
            if (vlq_count >= 3'd4) err = ERR_LONG;
          end else begin
            skip_left_next = vlq_word;
            if (vlq_word == 32'd0) boundary = 1'b1;
            else phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_left_next = skip_dec;
          if (skip_dec == 32'd0) boundary = 1'b1;
        end
        PH_DATA1: begin
          first_data_next = b;
          phase_next = PH_DATA2;
        end
        PH_DATA2: begin
          ra.kind = KIND_NOTE;
          ra.track_index = current_track;
          ra.note_ticks = tick_total;
          ra.channel = running_status[3:0];
          ra.note = first_data;
          ra.velocity = b;
          n = 2'd1;
          boundary = 1'b1;
        end
        default: ;
      endcase

      // advance to next event or close the track
      if (boundary) begin
        if (used >= track_length_next) begin
          current_track_next = trk_inc;
          if (trk_inc == tracks_expected) begin
            if (n == 2'd0) ra.kind = KIND_DONE;
            else rb.kind = KIND_DONE;
            n = n + 2'd1;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_TRK_ID;
            field_byte_count_next = 3'd0;
          end
        end else begin
          phase_next = PH_DELTA;
          gather_word_next = 32'd0;
          quantity_bytes_next = 3'd0;
        end
      end

      if (err == 3'd0 && in_data.end_of_file &&
          phase_next != PH_DONE && phase_next != PH_ERROR)
        err = ERR_TRUNC;

      // drop into error; at most one result precedes it
      if (err != 3'd0) begin
        if (n == 2'd0) begin
          ra = '0;
          ra.kind = KIND_ERROR;
          ra.track_index = current_track_next;
          ra.error_code = err;
        end else begin
          rb = '0;
          rb.kind = KIND_ERROR;
          rb.track_index = current_track_next;
          rb.error_code = err;
        end
        n = n + 2'd1;
        phase_next = PH_ERROR;
      end
    end

    if (n == 2'd1) ra.last_of_run = 1'b1;
    if (n == 2'd2) rb.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HDR_ID;
      field_byte_count <= 3'd0;
      gather_word      <= 32'd0;
      tracks_expected  <= 16'd0;
      current_track    <= 16'd0;
      track_length     <= 32'd0;
      track_bytes_used <= 32'd0;
      tick_total       <= 32'd0;
      running_status   <= 8'd0;
      quantity_bytes   <= 3'd0;
      skip_left        <= 32'd0;
      first_data       <= 8'd0;
      header_format    <= 16'd0;
    end else if (accept) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      gather_word      <= gather_word_next;
      tracks_expected  <= tracks_expected_next;
      current_track    <= current_track_next;
      track_length     <= track_length_next;
      track_bytes_used <= track_bytes_used_next;
      tick_total       <= tick_total_next;
      running_status   <= running_status_next;
      quantity_bytes   <= quantity_bytes_next;
      skip_left        <= skip_left_next;
      first_data       <= first_data_next;
      header_format    <= header_format_next;
    end
  end

  mfnp_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_count (n),
    .push_a     (ra),
    .push_b     (rb),
    .has_room   (in_ready),
    .out_valid  (out_valid),
    .out_item   (out_data),
    .out_ready  (out_ready)
  );
endmodule

@@ tb/tb_midi_file_note_on_parser.sv @@
module tb_midi_file_note_on_parser;
  import mfnp_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  midi_file_note_on_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Parser state mirrored at the block's widths.
  phase_t      ph;
  logic [2:0]  fcnt;
  logic [31:0] gword;
  logic [15:0] ntrk_exp;
  logic [15:0] cur_trk;
  logic [31:0] trk_len;
  logic [31:0] trk_used;
  logic [31:0] ticks;
  logic [7:0]  run_stat;
  logic [2:0]  vlq_cnt;
  logic [31:0] skip_cnt;
  logic [7:0]  note_byte;
  logic [15:0] fmt_word;

  out_item_t note_results_q[$];
  int n_mism;
  int n_results;
  int n_requests;
  int n_notes;
  int n_errors;
  int idle_pct;
  int quiet_cycles;

  function automatic out_item_t blank_result(logic [1:0] k);
    out_item_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  // Results produced by one byte are collected here, then last_of_run is
  // stamped on the final one before they join the expected queue.
  out_item_t byte_results[$];

  task automatic push_error(logic [2:0] code);
    out_item_t r;
    r = blank_result(KIND_ERROR);
    r.track_index = cur_trk;
    r.error_code = code;
    byte_results.push_back(r);
    ph = PH_ERROR;
  endtask

  // Return 0 pending, 1 complete, 2 too long.
  function automatic int vlq_step(logic [7:0] b);
    gword = {gword[24:0], b[6:0]};
    vlq_cnt = vlq_cnt + 3'd1;
    if (b[7]) return (vlq_cnt >= 3'd4) ? 2 : 0;
    return 1;
  endfunction

  function automatic logic [31:0] msg_data_len(logic [7:0] s);
    return (s[7:4] >= 4'hc && s[7:4] < 4'he) ? 32'd1 : 32'd2;
  endfunction

  task automatic between_events();
    if (trk_used >= trk_len) begin
      cur_trk = cur_trk + 16'd1;
      if (cur_trk == ntrk_exp) begin
        byte_results.push_back(blank_result(KIND_DONE));
        ph = PH_DONE;
      end else begin
        ph = PH_TRK_ID;
        fcnt = '0;
      end
    end else begin
      ph = PH_DELTA;
      gword = '0;
      vlq_cnt = '0;
    end
  endtask

  task automatic reset_parser();
    ph = PH_HDR_ID;
    fcnt = '0; gword = '0; ntrk_exp = '0; cur_trk = '0; trk_len = '0;
    trk_used = '0; ticks = '0; run_stat = '0; vlq_cnt = '0; skip_cnt = '0;
    note_byte = '0; fmt_word = '0;
  endtask

  // Advance the mirrored parser by one file byte and queue what it emits.
  task automatic parse_byte(in_item_t it);
    logic [7:0] b;
    int v;
    out_item_t r;
    b = it.in_byte;
    byte_results.delete();
    if (ph >= PH_DELTA && ph <= PH_DATA2) trk_used = trk_used + 32'd1;
    case (ph)
      PH_HDR_ID: begin
        if (b != ((fcnt[1:0] == 0) ? 8'h4d : (fcnt[1:0] == 1) ? 8'h54 :
                  (fcnt[1:0] == 2) ? 8'h68 : 8'h64)) push_error(ERR_HDR_ID);
        else begin
          fcnt = fcnt + 3'd1;
          if (fcnt >= 3'd4) begin fcnt = '0; ph = PH_HDR_LEN; end
        end
      end
      PH_HDR_LEN: begin
        fcnt = fcnt + 3'd1;
        if (fcnt >= 3'd4) begin fcnt = '0; gword = '0; ph = PH_HDR_FMT; end
      end
      PH_HDR_FMT, PH_HDR_NTRK, PH_HDR_DIV: begin
        gword = {gword[23:0], b};
        fcnt = fcnt + 3'd1;
        if (fcnt >= 3'd2) begin
          fcnt = '0;
          if (ph == PH_HDR_FMT) begin
            fmt_word = gword[15:0];
            ph = PH_HDR_NTRK;
          end else if (ph == PH_HDR_NTRK) begin
            ntrk_exp = gword[15:0];
            ph = PH_HDR_DIV;
          end else begin
            r = blank_result(KIND_HEADER);
            r.file_format = fmt_word;
            r.track_total = ntrk_exp;
            r.tick_division = gword[15:0];
            byte_results.push_back(r);
            cur_trk = '0;
            if (ntrk_exp == 16'd0) begin
              byte_results.push_back(blank_result(KIND_DONE));
              ph = PH_DONE;
            end else ph = PH_TRK_ID;
          end
          gword = '0;
        end
      end
      PH_TRK_ID: begin
        if (b != ((fcnt[1:0] == 0) ? 8'h4d : (fcnt[1:0] == 1) ? 8'h54 :
                  (fcnt[1:0] == 2) ? 8'h72 : 8'h6b)) push_error(ERR_TRK_ID);
        else begin
          fcnt = fcnt + 3'd1;
          if (fcnt >= 3'd4) begin fcnt = '0; gword = '0; ph = PH_TRK_LEN; end
        end
      end
      PH_TRK_LEN: begin
        gword = {gword[23:0], b};
        fcnt = fcnt + 3'd1;
        if (fcnt >= 3'd4) begin
          fcnt = '0;
          trk_len = gword;
          trk_used = '0;
          ticks = '0;
          run_stat = '0;
          between_events();
        end
      end
      PH_DELTA: begin
        v = vlq_step(b);
        if (v == 2) push_error(ERR_LONG);
        else if (v == 1) begin
          ticks = ticks + gword;
          ph = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (b[7]) begin
          if (b == 8'hff) begin
            run_stat = '0;
            ph = PH_META_TYPE;
          end else if (b == 8'hf0 || b == 8'hf7) begin
            run_stat = '0;
            gword = '0; vlq_cnt = '0;
            ph = PH_LEN_VLQ;
          end else begin
            run_stat = (b < 8'hf0) ? b : 8'h00;
            if (b[7:4] == 4'h9) ph = PH_DATA1;
            else begin
              skip_cnt = msg_data_len(b);
              ph = PH_SKIP;
            end
          end
        end else if (run_stat == 8'h00) push_error(ERR_NO_STAT);
        else if (run_stat[7:4] == 4'h9) begin
          note_byte = b;
          ph = PH_DATA2;
        end else if (msg_data_len(run_stat) == 32'd1) between_events();
        else begin
          skip_cnt = 32'd1;
          ph = PH_SKIP;
        end
      end
      PH_META_TYPE: begin
        gword = '0; vlq_cnt = '0;
        ph = PH_LEN_VLQ;
      end
      PH_LEN_VLQ: begin
        v = vlq_step(b);
        if (v == 2) push_error(ERR_LONG);
        else if (v == 1) begin
          skip_cnt = gword;
          if (skip_cnt == 32'd0) between_events();
          else ph = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_cnt != 32'd0) skip_cnt = skip_cnt - 32'd1;
        if (skip_cnt == 32'd0) between_events();
      end
      PH_DATA1: begin
        note_byte = b;
        ph = PH_DATA2;
      end
      PH_DATA2: begin
        r = blank_result(KIND_NOTE);
        r.track_index = cur_trk;
        r.note_ticks = ticks;
        r.channel = run_stat[3:0];
        r.note = note_byte;
        r.velocity = b;
        byte_results.push_back(r);
        between_events();
      end
      default: ;
    endcase
    // A file that stops early is flagged after whatever this byte produced.
    if (it.end_of_file && ph != PH_DONE && ph != PH_ERROR) push_error(ERR_TRUNC);
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last_of_run = 1'b1;
    foreach (byte_results[i]) note_results_q.push_back(byte_results[i]);
  endtask

  // Prediction runs at the accepting edge, so expectations are queued
  // before any result the byte causes can appear.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      n_requests++;
      parse_byte(in_data);
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (out_data.kind == KIND_NOTE) n_notes++;
      if (out_data.kind == KIND_ERROR) n_errors++;
      if (note_results_q.size() == 0) begin
        n_mism++;
        if (n_mism <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = note_results_q.pop_front();
        if (want !== out_data) begin
          n_mism++;
          if (n_mism <= 10) $display("result mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  // Receiver: stall at random, except during quiet stretches.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("watchdog expired");
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one byte and hold it until it is taken, with random gaps first.
  // Valid stays high after the last request; idle gaps or the drain drop it.
  task automatic send_byte(logic [7:0] b, logic eof = 1'b0);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, end_of_file: eof};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_word(logic [31:0] w, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  // Hold off the sender until every expected result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (note_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Build one delta time as a variable-length quantity.
  task automatic send_vlq(logic [27:0] v);
    int nb;
    nb = (v >= 28'h200000) ? 4 : (v >= 28'h4000) ? 3 : (v >= 28'h80) ? 2 : 1;
    for (int i = nb - 1; i >= 0; i--) send_byte({(i != 0), v[7*i +: 7]});
  endtask

  task automatic send_header(logic [15:0] fmt, logic [15:0] ntrk, logic [15:0] div);
    send_word(32'h4d546864, 4);
    send_word(32'h00000006, 4);
    send_word({16'd0, fmt}, 2);
    send_word({16'd0, ntrk}, 2);
    send_word({16'd0, div}, 2);
  endtask

  // Since reset happens once, the whole run is one file that ends in done.
  task automatic test_header_and_tracks();
    send_header(16'hffff, 16'd0 + 16'd40, 16'h0000);
  endtask

  // Random track: a mix of note on, running status, other channel messages,
  // meta, system exclusive and other system messages, with track length matched to the content.
  logic [7:0] trk_buf[$];
  int trk_first_len;

  function automatic void buf_vlq(logic [27:0] v);
    int nb;
    nb = (v >= 28'h200000) ? 4 : (v >= 28'h4000) ? 3 : (v >= 28'h80) ? 2 : 1;
    for (int i = nb - 1; i >= 0; i--) trk_buf.push_back({(i != 0), v[7*i +: 7]});
  endfunction

  function automatic void build_track(int n_events, bit extremes);
    logic [7:0] st;
    int sel;
    int len;
    trk_buf.delete();
    st = 8'h00;
    for (int e = 0; e < n_events; e++) begin
      case ($urandom_range(3))
        0: buf_vlq(28'd0);
        1: buf_vlq(28'($urandom_range(127)));
        2: buf_vlq(28'($urandom_range(32'h3fff)));
        default: buf_vlq(extremes ? 28'hfffffff : 28'($urandom()));
      endcase
      sel = $urandom_range(19);
      if (sel < 8 || st == 8'h00) begin
        st = {4'h9, 4'($urandom())};
        trk_buf.push_back(st);
        trk_buf.push_back(8'($urandom()));
        trk_buf.push_back(8'($urandom()));
      end else if (sel < 12) begin
        // running status: data bytes only
        trk_buf.push_back({1'b0, 7'($urandom())});
        if (msg_data_len(st) == 2) trk_buf.push_back(8'($urandom()));
      end else if (sel < 15) begin
        st = {3'($urandom_range(4, 7)) == 3'd7 ? 4'he : 4'($urandom_range(8, 14)),
              4'($urandom())};
        if (st[7:4] == 4'h9) st[7:4] = 4'h8;
        trk_buf.push_back(st);
        for (int k = 0; k < msg_data_len(st); k++) trk_buf.push_back(8'($urandom()));
      end else if (sel < 17) begin
        st = 8'h00;
        trk_buf.push_back(8'hff);
        trk_buf.push_back(8'($urandom()));
        len = $urandom_range(3);
        if ($urandom_range(9) == 0) len = 130;
        buf_vlq(28'(len));
        for (int k = 0; k < len; k++) trk_buf.push_back(8'($urandom()));
      end else if (sel < 19) begin
        st = 8'h00;
        trk_buf.push_back($urandom_range(1) ? 8'hf0 : 8'hf7);
        len = $urandom_range(4);
        buf_vlq(28'(len));
        for (int k = 0; k < len; k++) trk_buf.push_back(8'($urandom()));
      end else begin
        st = 8'h00;
        trk_buf.push_back(8'($urandom_range(8'hf1, 8'hfe)));
        if (trk_buf[trk_buf.size() - 1] inside {8'hf7, 8'hff, 8'hf0})
          trk_buf[trk_buf.size() - 1] = 8'hf1;
        trk_buf.push_back(8'($urandom()));
        trk_buf.push_back(8'($urandom()));
      end
      // a short declared length closes the track right after this event
      if (e == 0) trk_first_len = trk_buf.size();
    end
  endfunction

  task automatic send_track(int n_events, bit extremes, bit short_len);
    build_track(n_events, extremes);
    send_word(32'h4d54726b, 4);
    // A short declared length ends the track after the first event.
    send_word(short_len ? 32'd1 : 32'(trk_buf.size()), 4);
    if (short_len) begin
      for (int i = 0; i < trk_first_len; i++) send_byte(trk_buf[i]);
    end else foreach (trk_buf[i]) send_byte(trk_buf[i]);
  endtask

  task automatic test_random_tracks(int n_tracks);
    for (int t = 0; t < n_tracks; t++) begin
      if (t == 10) idle_pct = 0;
      if (t == 16) idle_pct = 38;
      if (t == 20) wait_drained();
      send_track($urandom_range(3, 11), (t % 7) == 0, (t % 9) == 4);
    end
  endtask

  // After done, bytes are ignored; then end the file flag has no effect.
  task automatic test_after_done();
    for (int i = 0; i < 20; i++) send_byte(8'($urandom()), i == 19);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    idle_pct = 38;
    n_mism = 0; n_results = 0; n_requests = 0; n_notes = 0; n_errors = 0;
    quiet_cycles = 0;
    reset_parser();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_and_tracks();
    test_random_tracks(40);
    test_after_done();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("covered %0d file bytes, %0d results, %0d note on", n_requests,
             n_results, n_notes);
    $display("header, running status, meta, sysex, system and short-length tracks");
    if (n_mism == 0 && note_results_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
